>>> design/sht_pkg.sv
// ----------------------------------------------------------------------------
// sht_pkg
// Shared types and constants for the scheduled hysteresis thermostat.
// ----------------------------------------------------------------------------
package sht_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 12;

  // Register indexes on the configuration port
  localparam logic [CfgAddrW-1:0] REG_DAY_MASK       = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_WINDOW_START   = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_WINDOW_END     = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_LOW_THRESHOLD  = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_HIGH_THRESHOLD = 3'd4;

  localparam logic [6:0]  ALL_DAYS         = 7'h7F;
  localparam logic [10:0] MINUTES_PER_HOUR = 11'd60;

  localparam logic [6:0]         DAY_MASK_RST  = 7'h7F;
  localparam logic [10:0]        WINDOW_RST    = 11'd0;
  localparam logic signed [11:0] LOW_THR_RST   = 12'sd18;
  localparam logic signed [11:0] HIGH_THR_RST  = 12'sd22;

  typedef struct packed {
    logic [6:0]         day_mask;
    logic [10:0]        window_start;
    logic [10:0]        window_end;
    logic signed [11:0] low_threshold;
    logic signed [11:0] high_threshold;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         weekday;
    logic [4:0]         hour_now;
    logic [5:0]         minute_now;
    logic signed [15:0] measured_value;
    logic               relay_is_on;
  } tick_t;

  typedef struct packed {
    logic command_valid;
    logic command_level;
    logic heating_active;
  } result_t;

endpackage

>>> design/sht_decide.sv
// ----------------------------------------------------------------------------
// sht_decide
// Schedule and hysteresis decision for one tick; pure combinational logic.
// ----------------------------------------------------------------------------
module sht_decide (
  input  sht_pkg::cfg_t    cfg_i,
  input  sht_pkg::tick_t   tick_i,
  input  logic             flag_i,
  output sht_pkg::result_t res_o
);

  logic               enabled;
  logic [10:0]        minute_of_day;
  logic               in_window;
  logic               window_fwd;
  logic signed [15:0] lo_level;
  logic signed [15:0] hi_level;
  logic [2:0]         day_idx;

  assign day_idx = tick_i.weekday - 3'd1;

  always_comb begin
    if (cfg_i.day_mask == sht_pkg::ALL_DAYS) begin
      enabled = 1'b1;
    end else if (tick_i.weekday != 3'd0) begin
      enabled = cfg_i.day_mask[day_idx];
    end else begin
      enabled = 1'b0;
    end
  end

  // hour * 60 + minute, at most 1923
  assign minute_of_day = 11'(tick_i.hour_now) * sht_pkg::MINUTES_PER_HOUR
                         + 11'(tick_i.minute_now);

  assign window_fwd = cfg_i.window_start < cfg_i.window_end;

  always_comb begin
    if (cfg_i.window_start == cfg_i.window_end) begin
      in_window = 1'b1;
    end else if (window_fwd) begin
      in_window = (minute_of_day >= cfg_i.window_start) &&
                  (minute_of_day <= cfg_i.window_end);
    end else begin
      in_window = (minute_of_day >= cfg_i.window_start) ||
                  (minute_of_day <= cfg_i.window_end);
    end
  end

  // thresholds are whole degrees, the measurement is in sixteenths
  assign lo_level = {cfg_i.low_threshold, 4'b0000};
  assign hi_level = {cfg_i.high_threshold, 4'b0000};

  always_comb begin
    res_o.command_valid  = 1'b0;
    res_o.command_level  = 1'b0;
    res_o.heating_active = flag_i;
    if (enabled) begin
      if (in_window) begin
        if (tick_i.measured_value < lo_level) begin
          if (!tick_i.relay_is_on) begin
            res_o.command_valid  = 1'b1;
            res_o.command_level  = 1'b1;
            res_o.heating_active = 1'b1;
          end
        end else if (tick_i.measured_value > hi_level) begin
          if (tick_i.relay_is_on) begin
            res_o.command_valid  = 1'b1;
            res_o.heating_active = 1'b0;
          end
        end
      end else if (window_fwd && flag_i && tick_i.relay_is_on) begin
        // outside a daytime window: drop heating we started
        res_o.command_valid  = 1'b1;
        res_o.heating_active = 1'b0;
      end
    end
  end

endmodule

>>> design/scheduled_hysteresis_thermostat.sv
// ----------------------------------------------------------------------------
// scheduled_hysteresis_thermostat
// Weekly-scheduled hysteresis control of a heating relay, one result per tick.
// ----------------------------------------------------------------------------
// Each input transfer yields exactly one output transfer, through the input
// register and then the result register. A new tick is accepted every cycle
// unless the output stalls; the heating flag is updated in the same cycle that
// loads the result register, so each tick sees the flag left by the one before
// it. Configuration writes take effect at the next clock edge; the user must
// make them while no tick is in flight, which the block does not enforce.
module scheduled_hysteresis_thermostat (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [sht_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [sht_pkg::CfgDataW-1:0]  cfg_data_i,
  // ticks in
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [2:0] weekday, [7:3] hour_now, [13:8] minute_now, [29:14] measured_value,
  // [30] relay_is_on, [31] zero
  input  logic [31:0]                   s_axis_tdata_i,
  // results out
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] command_valid, [1] command_level, [2] heating_active, [7:3] zero
  output logic [7:0]                    m_axis_tdata_o
);

  sht_pkg::cfg_t    cfg_q;
  sht_pkg::tick_t   tick_q;
  logic             in_valid_q;
  logic             out_valid_q;
  sht_pkg::result_t res_d;
  sht_pkg::result_t res_q;
  logic             flag_q;
  logic             advance;

  // ---- configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.day_mask       <= sht_pkg::DAY_MASK_RST;
      cfg_q.window_start   <= sht_pkg::WINDOW_RST;
      cfg_q.window_end     <= sht_pkg::WINDOW_RST;
      cfg_q.low_threshold  <= sht_pkg::LOW_THR_RST;
      cfg_q.high_threshold <= sht_pkg::HIGH_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        sht_pkg::REG_DAY_MASK:       cfg_q.day_mask       <= cfg_data_i[6:0];
        sht_pkg::REG_WINDOW_START:   cfg_q.window_start   <= cfg_data_i[10:0];
        sht_pkg::REG_WINDOW_END:     cfg_q.window_end     <= cfg_data_i[10:0];
        sht_pkg::REG_LOW_THRESHOLD:  cfg_q.low_threshold  <= cfg_data_i;
        sht_pkg::REG_HIGH_THRESHOLD: cfg_q.high_threshold <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- handshake: advance when the result register is free or drains
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      tick_q.weekday        <= s_axis_tdata_i[2:0];
      tick_q.hour_now       <= s_axis_tdata_i[7:3];
      tick_q.minute_now     <= s_axis_tdata_i[13:8];
      tick_q.measured_value <= s_axis_tdata_i[29:14];
      tick_q.relay_is_on    <= s_axis_tdata_i[30];
    end
  end

  sht_decide u_decide (
    .cfg_i  (cfg_q),
    .tick_i (tick_q),
    .flag_i (flag_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      flag_q      <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        flag_q      <= res_d.heating_active;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b00000, res_q.heating_active, res_q.command_level,
                            res_q.command_valid};

  // ---- checks
  a_flag_matches_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (flag_q == res_q.heating_active))
    else $error("heating flag differs from the reported heating_active");

  a_no_on_with_relay_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && tick_q.relay_is_on) |=> !(res_q.command_valid && res_q.command_level))
    else $error("on command issued while relay already on");

  a_tick_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("stalled tick dropped from input register");

  a_flag_change_commanded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (res_d.heating_active != flag_q)) |-> res_d.command_valid)
    else $error("heating flag changed without a command");

endmodule

>>> sim/sht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sht_checker
// Watches the configuration port and both streams of the thermostat, predicts
// one command per accepted tick and compares each result transfer against it.
// ----------------------------------------------------------------------------
module sht_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sht_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [sht_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  // [2:0] weekday, [7:3] hour_now, [13:8] minute_now, [29:14] measured_value,
  // [30] relay_is_on, [31] zero
  input  logic [31:0]                  s_tdata_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  // [0] command_valid, [1] command_level, [2] heating_active, [7:3] zero
  input  logic [7:0]                   m_tdata_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  localparam int unsigned MinPerHour = 60;

  sht_pkg::cfg_t    sched_cfg;
  logic             heat_flag;
  sht_pkg::result_t pending_cmds_q[$];
  sht_pkg::result_t got_cmd;
  sht_pkg::result_t want_cmd;
  sht_pkg::tick_t   tick;

  // Predict one tick against the current schedule and advance the heating flag.
  function automatic sht_pkg::result_t thermostat_step(input sht_pkg::tick_t tk);
    sht_pkg::result_t res;
    logic             day_on;
    logic             in_win;
    int unsigned      mod_min;
    int unsigned      w_open;
    int unsigned      w_close;
    int               temp16;
    int               lo16;
    int               hi16;
    res     = '0;
    w_open  = sched_cfg.window_start;
    w_close = sched_cfg.window_end;
    if (sched_cfg.day_mask == sht_pkg::ALL_DAYS) begin
      day_on = 1'b1;
    end else if (tk.weekday != 3'd0) begin
      day_on = sched_cfg.day_mask[tk.weekday - 3'd1];
    end else begin
      day_on = 1'b0;
    end
    if (day_on) begin
      mod_min = int'(tk.hour_now) * MinPerHour + int'(tk.minute_now);
      if (w_open == w_close) begin
        in_win = 1'b1;
      end else if (w_open < w_close) begin
        in_win = (mod_min >= w_open) && (mod_min <= w_close);
      end else begin
        in_win = (mod_min >= w_open) || (mod_min <= w_close);
      end
      if (in_win) begin
        temp16 = int'($signed(tk.measured_value));
        lo16   = int'($signed(sched_cfg.low_threshold)) * 16;
        hi16   = int'($signed(sched_cfg.high_threshold)) * 16;
        if (temp16 < lo16) begin
          if (!tk.relay_is_on) begin
            res.command_valid = 1'b1;
            res.command_level = 1'b1;
            heat_flag         = 1'b1;
          end
        end else if (temp16 > hi16) begin
          if (tk.relay_is_on) begin
            res.command_valid = 1'b1;
            heat_flag         = 1'b0;
          end
        end
      end else if (w_open < w_close && heat_flag && tk.relay_is_on) begin
        // left a plain window with heating still on: switch off
        res.command_valid = 1'b1;
        heat_flag         = 1'b0;
      end
    end
    res.heating_active = heat_flag;
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sched_cfg.day_mask       = sht_pkg::DAY_MASK_RST;
      sched_cfg.window_start   = sht_pkg::WINDOW_RST;
      sched_cfg.window_end     = sht_pkg::WINDOW_RST;
      sched_cfg.low_threshold  = sht_pkg::LOW_THR_RST;
      sched_cfg.high_threshold = sht_pkg::HIGH_THR_RST;
      heat_flag                = 1'b0;
      pending_cmds_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          sht_pkg::REG_DAY_MASK:       sched_cfg.day_mask       = cfg_data_i[6:0];
          sht_pkg::REG_WINDOW_START:   sched_cfg.window_start   = cfg_data_i[10:0];
          sht_pkg::REG_WINDOW_END:     sched_cfg.window_end     = cfg_data_i[10:0];
          sht_pkg::REG_LOW_THRESHOLD:  sched_cfg.low_threshold  = cfg_data_i;
          sht_pkg::REG_HIGH_THRESHOLD: sched_cfg.high_threshold = cfg_data_i;
          default: ;
        endcase
      end
      // compare before pushing: a tick never comes out in its own cycle
      if (m_tvalid_i && m_tready_i) begin
        got_cmd.command_valid  = m_tdata_i[0];
        got_cmd.command_level  = m_tdata_i[1];
        got_cmd.heating_active = m_tdata_i[2];
        if (pending_cmds_q.size() == 0) begin
          $error("result transfer with nothing expected: %b", m_tdata_i);
          fail_count_o++;
        end else begin
          want_cmd = pending_cmds_q.pop_front();
          if (got_cmd.command_valid !== want_cmd.command_valid) begin
            $error("command_valid: expected %0b, got %0b",
                   want_cmd.command_valid, got_cmd.command_valid);
            fail_count_o++;
          end
          if (got_cmd.command_level !== want_cmd.command_level) begin
            $error("command_level: expected %0b, got %0b",
                   want_cmd.command_level, got_cmd.command_level);
            fail_count_o++;
          end
          if (got_cmd.heating_active !== want_cmd.heating_active) begin
            $error("heating_active: expected %0b, got %0b",
                   want_cmd.heating_active, got_cmd.heating_active);
            fail_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        tick.weekday        = s_tdata_i[2:0];
        tick.hour_now       = s_tdata_i[7:3];
        tick.minute_now     = s_tdata_i[13:8];
        tick.measured_value = s_tdata_i[29:14];
        tick.relay_is_on    = s_tdata_i[30];
        pending_cmds_q.push_back(thermostat_step(tick));
      end
    end
    pending_o = pending_cmds_q.size();
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives ticks and schedule settings into the thermostat: a directed set of
// edge cases, then random ticks over several schedules and handshake loads.
// ----------------------------------------------------------------------------
module tb_top;

  logic                         clk      = 1'b0;
  logic                         rst_n    = 1'b0;
  logic                         cfg_we   = 1'b0;
  logic [sht_pkg::CfgAddrW-1:0] cfg_addr = '0;
  logic [sht_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [31:0]                  s_tdata  = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [7:0]                   m_tdata;
  int                           fail_count;
  int                           pending;

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int cur_open;
  int cur_close;
  int cur_lo;
  int cur_hi;

  always #4 clk = ~clk;

  scheduled_hysteresis_thermostat u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  sht_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  initial begin
    #5ms;
    $display("scheduled_hysteresis_thermostat: mismatch");
    $finish;
  end

  function automatic logic [31:0] pack_tick(input logic [2:0] wd, input logic [4:0] hr,
                                            input logic [5:0] mn, input logic [15:0] meas,
                                            input logic relay);
    return {1'b0, relay, meas, mn, hr, wd};
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_tick(input logic [31:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [sht_pkg::CfgAddrW-1:0] idx,
                           input logic [sht_pkg::CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Hold the input until every result is back, then let the pipeline empty.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_schedule;
    int sel;
    sel = $urandom_range(3);
    case (sel)
      0: write_reg(sht_pkg::REG_DAY_MASK, {5'($urandom), 7'h7F});
      1: write_reg(sht_pkg::REG_DAY_MASK, 12'h000);
      default: write_reg(sht_pkg::REG_DAY_MASK, 12'($urandom));
    endcase
    sel = $urandom_range(3);
    case (sel)
      0: begin
        cur_open  = $urandom_range(1439);
        cur_close = cur_open;
      end
      1: begin
        cur_open  = $urandom_range(1400);
        cur_close = cur_open + $urandom_range(1439 - cur_open, 1);
      end
      2: begin
        cur_close = $urandom_range(1400);
        cur_open  = cur_close + $urandom_range(1439 - cur_close, 1);
      end
      default: begin
        cur_open  = $urandom_range(2047);
        cur_close = $urandom_range(2047);
      end
    endcase
    write_reg(sht_pkg::REG_WINDOW_START, 12'(cur_open));
    write_reg(sht_pkg::REG_WINDOW_END, 12'(cur_close));
    if ($urandom_range(1)) begin
      cur_lo = $urandom_range(25, 10);
      cur_hi = cur_lo + $urandom_range(6);
    end else begin
      cur_lo = int'($urandom_range(4095)) - 2048;
      cur_hi = int'($urandom_range(4095)) - 2048;
    end
    write_reg(sht_pkg::REG_LOW_THRESHOLD, 12'(cur_lo));
    write_reg(sht_pkg::REG_HIGH_THRESHOLD, 12'(cur_hi));
  endtask

  task automatic random_tick;
    logic [2:0]  wd;
    logic [4:0]  hr;
    logic [5:0]  mn;
    logic [15:0] meas;
    int          sel;
    int          t;
    wd = ($urandom_range(9) == 0) ? 3'd0 : 3'($urandom_range(7, 1));
    sel = $urandom_range(9);
    if (sel < 2) begin
      // aim at the window edges
      t = ($urandom_range(1) ? cur_open : cur_close) + int'($urandom_range(2)) - 1;
      if (t < 0) t = 0;
      if (t > 1439) t = 1439;
      hr = 5'(t / 60);
      mn = 6'(t % 60);
    end else begin
      hr = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 24)) : 5'($urandom_range(23));
      mn = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 60)) : 6'($urandom_range(59));
    end
    sel = $urandom_range(9);
    if (sel < 4) begin
      meas = 16'(cur_lo * 16 + int'($urandom_range(80)) - 40);
    end else if (sel < 8) begin
      meas = 16'(cur_hi * 16 + int'($urandom_range(80)) - 40);
    end else begin
      meas = 16'($urandom);
    end
    send_tick(pack_tick(wd, hr, mn, meas, 1'($urandom)));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset schedule: every day, whole-day window, thresholds 18 and 22.
    send_tick(pack_tick(3'd0, 5'd0, 6'd0, 16'd287, 1'b0));      // weekday zero, full mask
    send_tick(pack_tick(3'd1, 5'd23, 6'd59, 16'd288, 1'b0));    // exactly at low level
    send_tick(pack_tick(3'd7, 5'd12, 6'd30, 16'd352, 1'b1));    // exactly at high level
    send_tick(pack_tick(3'd7, 5'd31, 6'd63, 16'd353, 1'b1));    // out-of-range time
    send_tick(pack_tick(3'd3, 5'd5, 6'd5, 16'h8000, 1'b0));
    send_tick(pack_tick(3'd4, 5'd6, 6'd6, 16'h7FFF, 1'b1));
    send_tick(pack_tick(3'd5, 5'd6, 6'd6, 16'h8000, 1'b1));
    drain();

    // Sunday and Saturday only, plain window 08:00..17:00.
    write_reg(sht_pkg::REG_DAY_MASK, 12'hF41);
    write_reg(sht_pkg::REG_WINDOW_START, 12'd480);
    write_reg(sht_pkg::REG_WINDOW_END, 12'd1020);
    send_tick(pack_tick(3'd1, 5'd8, 6'd0, 16'd0, 1'b0));
    send_tick(pack_tick(3'd2, 5'd8, 6'd0, 16'd0, 1'b0));        // day disabled
    send_tick(pack_tick(3'd0, 5'd8, 6'd0, 16'd0, 1'b0));        // weekday zero disabled
    send_tick(pack_tick(3'd7, 5'd17, 6'd1, 16'd0, 1'b1));       // leave window heating
    send_tick(pack_tick(3'd7, 5'd17, 6'd0, 16'd0, 1'b0));       // inclusive end
    send_tick(pack_tick(3'd1, 5'd7, 6'd59, 16'd0, 1'b0));
    drain();

    // Wrapping window 22:00..06:00, extreme thresholds, stray indexes ignored.
    write_reg(sht_pkg::REG_DAY_MASK, 12'hFFF);
    write_reg(sht_pkg::REG_WINDOW_START, 12'd1320);
    write_reg(sht_pkg::REG_WINDOW_END, 12'd360);
    write_reg(sht_pkg::REG_LOW_THRESHOLD, 12'h800);
    write_reg(sht_pkg::REG_HIGH_THRESHOLD, 12'h7FF);
    write_reg(3'd5, 12'h000);
    write_reg(3'd7, 12'hFFF);
    send_tick(pack_tick(3'd2, 5'd23, 6'd0, 16'h8000, 1'b0));
    send_tick(pack_tick(3'd2, 5'd12, 6'd0, 16'd0, 1'b1));       // outside wrap: no action
    send_tick(pack_tick(3'd2, 5'd6, 6'd0, 16'h7FFF, 1'b1));
    send_tick(pack_tick(3'd3, 5'd6, 6'd1, 16'h7FFF, 1'b1));
    drain();

    // Nothing enabled, window start above a day's length.
    write_reg(sht_pkg::REG_DAY_MASK, 12'h000);
    write_reg(sht_pkg::REG_WINDOW_START, 12'd2047);
    write_reg(sht_pkg::REG_WINDOW_END, 12'd0);
    write_reg(sht_pkg::REG_LOW_THRESHOLD, 12'h7FF);
    write_reg(sht_pkg::REG_HIGH_THRESHOLD, 12'h800);
    send_tick(pack_tick(3'd1, 5'd0, 6'd0, 16'd0, 1'b0));
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 83; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 83; end
        default: begin src_idle_pct = 32; snk_stall_pct = 32; end
      endcase
      random_schedule();
      repeat (206) random_tick();
      drain();
    end

    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("scheduled_hysteresis_thermostat: match");
    end else begin
      $display("scheduled_hysteresis_thermostat: mismatch");
    end
    $finish;
  end

endmodule
